>>> rtl/es2utc_pkg.sv
package es2utc_pkg;

    // Width of the signed seconds count that the block takes in.
    localparam int EPOCH_SECONDS_BITS = 40;

    localparam int SEC_DAY_SHIFT = 7;
    localparam int DAY_ODD       = 675;
    localparam int SECS_PER_DAY  = DAY_ODD << SEC_DAY_SHIFT;
    localparam int DAYS_SHIFT    = 719468;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int ERA_LAST_DOE  = 146096;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int YEARS_PER_ERA = 400;
    localparam int YEAR_BASE     = 1900;
    localparam int DAYS_PER_YEAR = 365;
    localparam int DAYS_4_YEARS  = 1460;
    localparam int DAYS_100_YEARS = 36524;
    localparam int DAYS_PER_WEEK = 7;
    localparam int WEEKDAY_SKEW  = 3;
    localparam int DOY_JAN1      = 306;
    localparam int DAYS_BEFORE_MAR = 59;
    localparam int MP_JAN        = 10;

    // Pipeline depth.
    localparam int NS = 15;
    localparam logic [NS-1:0] VLD_ONE = 1;

    // Seconds are biased to a non-negative value that is a whole number of days.
    localparam int UW     = EPOCH_SECONDS_BITS + 1;
    localparam int QW     = UW - SEC_DAY_SHIFT;
    localparam int DAY_LO = QW / 2;
    localparam int DAY_HI = QW - DAY_LO;
    localparam int DW     = QW - 9;

    localparam longint SEC_BIAS_DAYS =
        ((longint'(1) <<< (EPOCH_SECONDS_BITS - 1)) + SECS_PER_DAY - 1) / SECS_PER_DAY;
    localparam longint SEC_BIAS = SEC_BIAS_DAYS * SECS_PER_DAY;
    localparam longint ERA_BIAS = (SEC_BIAS_DAYS + DAYS_PER_ERA - 1) / DAYS_PER_ERA;
    localparam longint Z_BIAS   = DAYS_SHIFT + ERA_BIAS * DAYS_PER_ERA - SEC_BIAS_DAYS;
    localparam longint YEAR_OFFSET = ERA_BIAS * YEARS_PER_ERA + YEAR_BASE;
    localparam longint DAYS_MAX =
        ((longint'(1) <<< EPOCH_SECONDS_BITS) + SECS_PER_DAY) / SECS_PER_DAY;

    localparam int ZW = $clog2(DAYS_MAX + Z_BIAS + WEEKDAY_SKEW + 1);
    localparam int EW = ZW - 17;

    // Reciprocals. The day split uses an estimate that is corrected once; the
    // others are exact for their whole input range.
    localparam longint M_DAY  = (longint'(1) <<< QW) / DAY_ODD;
    localparam int     S_ERA  = ZW + 18;
    localparam longint M_ERA  = ((longint'(1) <<< S_ERA) + DAYS_PER_ERA - 1) / DAYS_PER_ERA;
    localparam int     S_WK   = ZW + 3;
    localparam longint M_WK   = ((longint'(1) <<< S_WK) + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK;
    localparam int     S_HOUR = 29;
    localparam longint M_HOUR = ((longint'(1) <<< S_HOUR) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
    localparam int     S_MIN  = 18;
    localparam longint M_MIN  = ((longint'(1) <<< S_MIN) + SECS_PER_MIN - 1) / SECS_PER_MIN;
    localparam int     S_C4   = 29;
    localparam longint M_C4   = ((longint'(1) <<< S_C4) + DAYS_4_YEARS - 1) / DAYS_4_YEARS;
    localparam int     S_C100 = 34;
    localparam longint M_C100 =
        ((longint'(1) <<< S_C100) + DAYS_100_YEARS - 1) / DAYS_100_YEARS;
    localparam int     S_YOE  = 27;
    localparam longint M_YOE  = ((longint'(1) <<< S_YOE) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR;
    localparam int     S_Y100 = 16;
    localparam longint M_Y100 = ((longint'(1) <<< S_Y100) + 100 - 1) / 100;
    localparam int     S_MP   = 19;
    localparam longint M_MP   = ((longint'(1) <<< S_MP) + 153 - 1) / 153;

    typedef logic [UW-1:0]          t_u;
    typedef logic [DAY_LO+DW-1:0]   t_pp_lo;
    typedef logic [DAY_HI+DW-1:0]   t_pp_hi;
    typedef logic [QW+DW-1:0]       t_day_sum;
    typedef logic [DW-1:0]          t_days;
    typedef logic [ZW-1:0]          t_z;
    typedef logic [2*ZW:0]          t_zprod;
    typedef logic [EW-1:0]          t_era;
    typedef logic [ZW-3:0]          t_wq;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
        logic [15:0] ybase;
    } t_carry;

    // First day of each month counted from March 1.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        unique case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/epoch_seconds_to_utc_calendar_top.sv
// Throughput: one beat per cycle through a 15-stage pipeline, while the output is not stalled.
// A stalled result holds the last stage; empty stages upstream keep filling,
// so the input is only stalled when every stage holds a beat.
// Reset is synchronous and active low; it clears the stage valid bits only.
module epoch_seconds_to_utc_calendar_top (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_stall,
    input  logic signed [es2utc_pkg::EPOCH_SECONDS_BITS-1:0] i_epoch_seconds,
    output logic                                             o_valid,
    input  logic                                             i_stall,
    output logic signed [15:0]                               o_year_since_1900,
    output logic        [3:0]                                o_month_index,
    output logic        [4:0]                                o_day_of_month,
    output logic        [4:0]                                o_hour_of_day,
    output logic        [5:0]                                o_minute_of_hour,
    output logic        [5:0]                                o_second_of_minute,
    output logic        [2:0]                                o_weekday,
    output logic        [8:0]                                o_day_of_year
);

    logic [es2utc_pkg::NS-1:0] r_vld;
    logic [es2utc_pkg::NS-1:0] n_vld;
    logic [es2utc_pkg::NS-1:0] adv;

    es2utc_pkg::t_u       r1_u, n1_u;
    es2utc_pkg::t_pp_lo   r2_plo, n2_plo;
    es2utc_pkg::t_pp_hi   r2_phi, n2_phi;
    es2utc_pkg::t_u       r2_u;
    es2utc_pkg::t_day_sum day_sum;
    es2utc_pkg::t_days    r3_est, n3_est;
    es2utc_pkg::t_u       r3_u;
    es2utc_pkg::t_u       day_rem_full;
    es2utc_pkg::t_days    r4_est;
    logic [17:0]          r4_rem, n4_rem;
    es2utc_pkg::t_days    r5_days, n5_days;
    logic [16:0]          r5_sod, n5_sod;
    es2utc_pkg::t_z       r6_z, n6_z, r6_w, n6_w;
    logic [34:0]          hour_prod;
    logic [4:0]           r6_hour, n6_hour;
    logic [16:0]          r6_sod;
    es2utc_pkg::t_zprod   era_prod, wk_prod;
    es2utc_pkg::t_era     r7_era, n7_era;
    es2utc_pkg::t_wq      r7_wq, n7_wq;
    es2utc_pkg::t_z       r7_z, r7_w;
    logic [4:0]           r7_hour;
    logic [11:0]          r7_remh, n7_remh;
    logic [17:0]          r8_doe, n8_doe;
    logic [2:0]           r8_wday, n8_wday;
    logic [15:0]          r8_ybase, n8_ybase;
    logic [24:0]          min_prod;
    logic [5:0]           r8_min, n8_min;
    logic [4:0]           r8_hour;
    logic [11:0]          r8_remh;
    logic [36:0]          c4_prod, c100_prod;
    logic [17:0]          r9_doe;
    logic [6:0]           r9_q4, n9_q4;
    logic [2:0]           r9_q100, n9_q100;
    logic                 r9_qe, n9_qe;
    es2utc_pkg::t_carry   r9_cry, n9_cry;
    logic [17:0]          r10_a, n10_a;
    logic [17:0]          r10_doe;
    es2utc_pkg::t_carry   r10_cry;
    logic [36:0]          yoe_prod;
    logic [8:0]           r11_yoe, n11_yoe;
    logic [17:0]          r11_doe;
    es2utc_pkg::t_carry   r11_cry;
    logic [18:0]          y100_prod;
    logic [17:0]          r12_p, n12_p;
    logic [1:0]           r12_c100, n12_c100;
    logic                 r12_leap, n12_leap;
    logic [8:0]           r12_yoe;
    logic [17:0]          r12_doe;
    es2utc_pkg::t_carry   r12_cry;
    logic [8:0]           r13_doy, n13_doy;
    logic [8:0]           r13_yoe;
    logic                 r13_leap;
    es2utc_pkg::t_carry   r13_cry;
    logic [10:0]          mp_num;
    logic [22:0]          mp_prod;
    logic [3:0]           r14_mp, n14_mp;
    logic [8:0]           r14_yday, n14_yday;
    logic [8:0]           r14_doy;
    logic [8:0]           r14_yoe;
    es2utc_pkg::t_carry   r14_cry;
    logic [15:0]          r15_year, n15_year;
    logic [3:0]           r15_month, n15_month;
    logic [4:0]           r15_mday, n15_mday;
    logic [8:0]           r15_yday;
    es2utc_pkg::t_carry   r15_cry;

    // A stage moves when it is empty or when every stage after it moves.
    always_comb begin
        for (int j = 0; j < es2utc_pkg::NS; j++) begin
            adv[j] = !i_stall ||
                ((r_vld | ((es2utc_pkg::VLD_ONE << j) - es2utc_pkg::VLD_ONE))
                 != {es2utc_pkg::NS{1'b1}});
        end
        n_vld = {r_vld[es2utc_pkg::NS-2:0], i_valid};
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[es2utc_pkg::NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int j = 0; j < es2utc_pkg::NS; j++) begin
                if (adv[j]) begin
                    r_vld[j] <= n_vld[j];
                end
            end
        end
    end

    always_comb begin
        // Seconds split into days and second of day.
        n1_u = {{(es2utc_pkg::UW - es2utc_pkg::EPOCH_SECONDS_BITS)
                 {i_epoch_seconds[es2utc_pkg::EPOCH_SECONDS_BITS-1]}}, i_epoch_seconds}
               + es2utc_pkg::t_u'(es2utc_pkg::SEC_BIAS);

        n2_plo = es2utc_pkg::t_pp_lo'(r1_u[es2utc_pkg::SEC_DAY_SHIFT +: es2utc_pkg::DAY_LO])
                 * es2utc_pkg::t_pp_lo'(es2utc_pkg::M_DAY);
        n2_phi = es2utc_pkg::t_pp_hi'(r1_u[es2utc_pkg::SEC_DAY_SHIFT + es2utc_pkg::DAY_LO
                                           +: es2utc_pkg::DAY_HI])
                 * es2utc_pkg::t_pp_hi'(es2utc_pkg::M_DAY);

        day_sum = (es2utc_pkg::t_day_sum'(r2_phi) << es2utc_pkg::DAY_LO)
                  + es2utc_pkg::t_day_sum'(r2_plo);
        n3_est  = day_sum[es2utc_pkg::QW +: es2utc_pkg::DW];

        // The estimate is the day count or one below it.
        day_rem_full = r3_u - es2utc_pkg::t_u'(r3_est)
                       * es2utc_pkg::t_u'(es2utc_pkg::SECS_PER_DAY);
        n4_rem = 18'(day_rem_full);

        if (r4_rem >= 18'(es2utc_pkg::SECS_PER_DAY)) begin
            n5_days = r4_est + es2utc_pkg::t_days'(1);
            n5_sod  = 17'(r4_rem - 18'(es2utc_pkg::SECS_PER_DAY));
        end else begin
            n5_days = r4_est;
            n5_sod  = 17'(r4_rem);
        end

        // Day number shifted to March-based eras, biased to stay non-negative.
        n6_z = es2utc_pkg::t_z'(r5_days) + es2utc_pkg::t_z'(es2utc_pkg::Z_BIAS);
        n6_w = es2utc_pkg::t_z'(r5_days)
               + es2utc_pkg::t_z'(es2utc_pkg::Z_BIAS + es2utc_pkg::WEEKDAY_SKEW);
        hour_prod = 35'(r5_sod) * 35'(es2utc_pkg::M_HOUR);
        n6_hour   = hour_prod[es2utc_pkg::S_HOUR +: 5];

        era_prod = es2utc_pkg::t_zprod'(r6_z) * es2utc_pkg::t_zprod'(es2utc_pkg::M_ERA);
        n7_era   = era_prod[es2utc_pkg::S_ERA +: es2utc_pkg::EW];
        wk_prod  = es2utc_pkg::t_zprod'(r6_w) * es2utc_pkg::t_zprod'(es2utc_pkg::M_WK);
        n7_wq    = wk_prod[es2utc_pkg::S_WK +: (es2utc_pkg::ZW - 2)];
        n7_remh  = 12'(r6_sod - 17'(r6_hour) * 17'(es2utc_pkg::SECS_PER_HOUR));

        n8_doe   = 18'(r7_z - es2utc_pkg::t_z'(r7_era)
                           * es2utc_pkg::t_z'(es2utc_pkg::DAYS_PER_ERA));
        n8_wday  = 3'(r7_w - es2utc_pkg::t_z'(r7_wq)
                           * es2utc_pkg::t_z'(es2utc_pkg::DAYS_PER_WEEK));
        // Year arithmetic is kept modulo 2^16, matching the output field.
        n8_ybase = 16'(r7_era) * 16'(es2utc_pkg::YEARS_PER_ERA)
                   - 16'(es2utc_pkg::YEAR_OFFSET);
        min_prod = 25'(r7_remh) * 25'(es2utc_pkg::M_MIN);
        n8_min   = min_prod[es2utc_pkg::S_MIN +: 6];

        c4_prod   = 37'(r8_doe) * 37'(es2utc_pkg::M_C4);
        n9_q4     = c4_prod[es2utc_pkg::S_C4 +: 7];
        c100_prod = 37'(r8_doe) * 37'(es2utc_pkg::M_C100);
        n9_q100   = c100_prod[es2utc_pkg::S_C100 +: 3];
        n9_qe     = (r8_doe == 18'(es2utc_pkg::ERA_LAST_DOE));
        n9_cry.hour   = r8_hour;
        n9_cry.minute = r8_min;
        n9_cry.second = 6'(r8_remh - 12'(r8_min) * 12'(es2utc_pkg::SECS_PER_MIN));
        n9_cry.wday   = r8_wday;
        n9_cry.ybase  = r8_ybase;

        n10_a = r9_doe - 18'(r9_q4) + 18'(r9_q100) - 18'(r9_qe);

        yoe_prod = 37'(r10_a) * 37'(es2utc_pkg::M_YOE);
        n11_yoe  = yoe_prod[es2utc_pkg::S_YOE +: 9];

        n12_p     = 18'(r11_yoe) * 18'(es2utc_pkg::DAYS_PER_YEAR);
        y100_prod = 19'(r11_yoe) * 19'(es2utc_pkg::M_Y100);
        n12_c100  = y100_prod[es2utc_pkg::S_Y100 +: 2];
        // Year of era zero is a 400th year and therefore leap.
        n12_leap  = (r11_yoe[1:0] == 2'd0) && (r11_yoe != 9'd100)
                    && (r11_yoe != 9'd200) && (r11_yoe != 9'd300);

        n13_doy = 9'(r12_doe - (r12_p + 18'(r12_yoe >> 2) - 18'(r12_c100)));

        mp_num  = (11'(r13_doy) << 2) + 11'(r13_doy) + 11'd2;
        mp_prod = 23'(mp_num) * 23'(es2utc_pkg::M_MP);
        n14_mp  = mp_prod[es2utc_pkg::S_MP +: 4];
        if (r13_doy >= 9'(es2utc_pkg::DOY_JAN1)) begin
            n14_yday = r13_doy - 9'(es2utc_pkg::DOY_JAN1);
        end else begin
            n14_yday = r13_doy + 9'(es2utc_pkg::DAYS_BEFORE_MAR) + 9'(r13_leap);
        end

        n15_mday = 5'(r14_doy - es2utc_pkg::month_start(r14_mp) + 9'd1);
        if (r14_mp < 4'(es2utc_pkg::MP_JAN)) begin
            n15_month = r14_mp + 4'd2;
        end else begin
            n15_month = r14_mp - 4'(es2utc_pkg::MP_JAN);
        end
        n15_year = r14_cry.ybase + 16'(r14_yoe)
                   + 16'(r14_mp >= 4'(es2utc_pkg::MP_JAN));
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_u <= n1_u;
        end
        if (adv[1]) begin
            r2_plo <= n2_plo;
            r2_phi <= n2_phi;
            r2_u   <= r1_u;
        end
        if (adv[2]) begin
            r3_est <= n3_est;
            r3_u   <= r2_u;
        end
        if (adv[3]) begin
            r4_est <= r3_est;
            r4_rem <= n4_rem;
        end
        if (adv[4]) begin
            r5_days <= n5_days;
            r5_sod  <= n5_sod;
        end
        if (adv[5]) begin
            r6_z    <= n6_z;
            r6_w    <= n6_w;
            r6_hour <= n6_hour;
            r6_sod  <= r5_sod;
        end
        if (adv[6]) begin
            r7_era  <= n7_era;
            r7_wq   <= n7_wq;
            r7_z    <= r6_z;
            r7_w    <= r6_w;
            r7_hour <= r6_hour;
            r7_remh <= n7_remh;
        end
        if (adv[7]) begin
            r8_doe   <= n8_doe;
            r8_wday  <= n8_wday;
            r8_ybase <= n8_ybase;
            r8_min   <= n8_min;
            r8_hour  <= r7_hour;
            r8_remh  <= r7_remh;
        end
        if (adv[8]) begin
            r9_doe  <= r8_doe;
            r9_q4   <= n9_q4;
            r9_q100 <= n9_q100;
            r9_qe   <= n9_qe;
            r9_cry  <= n9_cry;
        end
        if (adv[9]) begin
            r10_a   <= n10_a;
            r10_doe <= r9_doe;
            r10_cry <= r9_cry;
        end
        if (adv[10]) begin
            r11_yoe <= n11_yoe;
            r11_doe <= r10_doe;
            r11_cry <= r10_cry;
        end
        if (adv[11]) begin
            r12_p    <= n12_p;
            r12_c100 <= n12_c100;
            r12_leap <= n12_leap;
            r12_yoe  <= r11_yoe;
            r12_doe  <= r11_doe;
            r12_cry  <= r11_cry;
        end
        if (adv[12]) begin
            r13_doy  <= n13_doy;
            r13_yoe  <= r12_yoe;
            r13_leap <= r12_leap;
            r13_cry  <= r12_cry;
        end
        if (adv[13]) begin
            r14_mp   <= n14_mp;
            r14_yday <= n14_yday;
            r14_doy  <= r13_doy;
            r14_yoe  <= r13_yoe;
            r14_cry  <= r13_cry;
        end
        if (adv[14]) begin
            r15_year  <= n15_year;
            r15_month <= n15_month;
            r15_mday  <= n15_mday;
            r15_yday  <= r14_yday;
            r15_cry   <= r14_cry;
        end
    end

    assign o_year_since_1900  = $signed(r15_year);
    assign o_month_index      = r15_month;
    assign o_day_of_month     = r15_mday;
    assign o_hour_of_day      = r15_cry.hour;
    assign o_minute_of_hour   = r15_cry.minute;
    assign o_second_of_minute = r15_cry.second;
    assign o_weekday          = r15_cry.wday;
    assign o_day_of_year      = r15_yday;

endmodule

>>> rtl/es2utc_checker.sv
module es2utc_checker (
    input logic                                             i_clk,
    input logic                                             i_rst_n,
    input logic                                             i_valid,
    input logic                                             o_stall,
    input logic signed [es2utc_pkg::EPOCH_SECONDS_BITS-1:0] i_epoch_seconds,
    input logic                                             o_valid,
    input logic                                             i_stall,
    input logic signed [15:0]                               o_year_since_1900,
    input logic        [3:0]                                o_month_index,
    input logic        [4:0]                                o_day_of_month,
    input logic        [4:0]                                o_hour_of_day,
    input logic        [5:0]                                o_minute_of_hour,
    input logic        [5:0]                                o_second_of_minute,
    input logic        [2:0]                                o_weekday,
    input logic        [8:0]                                o_day_of_year
);

    // A result beat that is held back stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_year_since_1900)
            && $stable(o_day_of_year) && $stable(o_second_of_minute))
        else $error("result beat changed while stalled");

    // With the output side free, the pipeline always takes a new beat.
    a_no_self_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is not stalled");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_month_index <= 4'd11 && o_day_of_month >= 5'd1
            && o_hour_of_day <= 5'd23 && o_minute_of_hour <= 6'd59
            && o_second_of_minute <= 6'd59 && o_weekday <= 3'd6
            && o_day_of_year <= 9'd365)
        else $error("calendar field out of range");

    // In January the day of year follows the day of month directly.
    a_january_yday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_month_index == 4'd0 |-> o_day_of_year == 9'(o_day_of_month) - 9'd1)
        else $error("day of year disagrees with January date");

endmodule

bind epoch_seconds_to_utc_calendar_top es2utc_checker u_es2utc_checker (.*);
